// File: hdl/bhtc_pkg.sv
// ----------------------------------------------------------------------------
// bhtc_pkg
// Types and constants shared by the battery hover throttle compensation block:
// register indexes and reset values, field widths, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bhtc_pkg;

	localparam int unsigned REG_W    = 16;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned VOLT_W   = 16;
	localparam int unsigned FILT_W   = 14;
	localparam int unsigned THR_W    = 16;
	localparam int unsigned OUT_FIELDS_W = VOLT_W + FILT_W + THR_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// The quotient of the interpolation divide never exceeds the throttle span.
	localparam int unsigned QUOT_W   = THR_W;
	localparam int unsigned DIV_CNT_W = $clog2(QUOT_W);

	localparam logic [FILT_W-1:0] FILT_MIN_MV = 14'd9000;
	localparam logic [FILT_W-1:0] FILT_MAX_MV = 14'd13000;

	// Register indexes in the configuration space.
	localparam logic [REG_IDX_W-1:0] REG_VOLT_BREAK_LOW      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_VOLT_BREAK_MID_LOW  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VOLT_BREAK_MID_HIGH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VOLT_BREAK_HIGH     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_THR_AT_LOW          = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_THR_AT_MID_LOW      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_THR_AT_MID_HIGH     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_THR_AT_HIGH         = 3'd7;

	localparam logic [REG_W-1:0] RST_VOLT_BREAK_LOW      = 16'd10500;
	localparam logic [REG_W-1:0] RST_VOLT_BREAK_MID_LOW  = 16'd11100;
	localparam logic [REG_W-1:0] RST_VOLT_BREAK_MID_HIGH = 16'd11700;
	localparam logic [REG_W-1:0] RST_VOLT_BREAK_HIGH     = 16'd12300;
	localparam logic [REG_W-1:0] RST_THR_AT_LOW          = 16'd39322;
	localparam logic [REG_W-1:0] RST_THR_AT_MID_LOW      = 16'd36045;
	localparam logic [REG_W-1:0] RST_THR_AT_MID_HIGH     = 16'd32768;
	localparam logic [REG_W-1:0] RST_THR_AT_HIGH         = 16'd29491;

	typedef struct packed {
		logic [REG_W-1:0] brk_low;
		logic [REG_W-1:0] brk_mid_low;
		logic [REG_W-1:0] brk_mid_high;
		logic [REG_W-1:0] brk_high;
		logic [REG_W-1:0] thr_low;
		logic [REG_W-1:0] thr_mid_low;
		logic [REG_W-1:0] thr_mid_high;
		logic [REG_W-1:0] thr_high;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VOLT,
		ST_FILT_A,
		ST_FILT_B,
		ST_FILT_C,
		ST_SEG,
		ST_PROD,
		ST_DIV_INIT,
		ST_DIV,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_VOLT,
		OP_FILT_A,
		OP_FILT_B,
		OP_FILT_C,
		OP_SEG,
		OP_PROD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_FINISH,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic interp;    // selected segment needs interpolation
		logic out_free;  // output register can take a result this cycle
	} dp_status_t;

endpackage

// File: hdl/bhtc_regs.sv
// ----------------------------------------------------------------------------
// bhtc_regs
// Configuration register file: four voltage breakpoints and four throttle
// values, written through a plain write port.
// ----------------------------------------------------------------------------
module bhtc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bhtc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bhtc_pkg::REG_W-1:0]     cfg_data,
	output bhtc_pkg::cfg_t                 cfg
);
	import bhtc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brk_low      <= RST_VOLT_BREAK_LOW;
			cfg_q.brk_mid_low  <= RST_VOLT_BREAK_MID_LOW;
			cfg_q.brk_mid_high <= RST_VOLT_BREAK_MID_HIGH;
			cfg_q.brk_high     <= RST_VOLT_BREAK_HIGH;
			cfg_q.thr_low      <= RST_THR_AT_LOW;
			cfg_q.thr_mid_low  <= RST_THR_AT_MID_LOW;
			cfg_q.thr_mid_high <= RST_THR_AT_MID_HIGH;
			cfg_q.thr_high     <= RST_THR_AT_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VOLT_BREAK_LOW:      cfg_q.brk_low      <= cfg_data;
				REG_VOLT_BREAK_MID_LOW:  cfg_q.brk_mid_low  <= cfg_data;
				REG_VOLT_BREAK_MID_HIGH: cfg_q.brk_mid_high <= cfg_data;
				REG_VOLT_BREAK_HIGH:     cfg_q.brk_high     <= cfg_data;
				REG_THR_AT_LOW:          cfg_q.thr_low      <= cfg_data;
				REG_THR_AT_MID_LOW:      cfg_q.thr_mid_low  <= cfg_data;
				REG_THR_AT_MID_HIGH:     cfg_q.thr_mid_high <= cfg_data;
				REG_THR_AT_HIGH:         cfg_q.thr_high     <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/bhtc_ctrl.sv
// ----------------------------------------------------------------------------
// bhtc_ctrl
// Sequencer for one sample: scale, filter, segment select, optional
// interpolation divide, then hand the result to the output register.
// ----------------------------------------------------------------------------
module bhtc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  bhtc_pkg::dp_status_t status,
	output bhtc_pkg::op_t        op
);
	import bhtc_pkg::*;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

	state_t                state_q, state_d;
	logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_cnt_d = div_cnt_q;
		op        = OP_NONE;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op      = OP_LOAD;
					state_d = ST_VOLT;
				end
			end
			ST_VOLT: begin
				op      = OP_VOLT;
				state_d = ST_FILT_A;
			end
			ST_FILT_A: begin
				op      = OP_FILT_A;
				state_d = ST_FILT_B;
			end
			ST_FILT_B: begin
				op      = OP_FILT_B;
				state_d = ST_FILT_C;
			end
			ST_FILT_C: begin
				op      = OP_FILT_C;
				state_d = ST_SEG;
			end
			ST_SEG: begin
				op      = OP_SEG;
				state_d = status.interp ? ST_PROD : ST_EMIT;
			end
			ST_PROD: begin
				op      = OP_PROD;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				op        = OP_DIV_INIT;
				div_cnt_d = '0;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				op        = OP_DIV_STEP;
				div_cnt_d = div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				op      = OP_FINISH;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					op      = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/bhtc_datapath.sv
// ----------------------------------------------------------------------------
// bhtc_datapath
// Shared multiplier, filter arithmetic, segment select, restoring divider for
// the interpolation and the output register, all stepped by controller ops.
// ----------------------------------------------------------------------------
module bhtc_datapath #(
	parameter int unsigned ADC_BITS       = 12,
	parameter int unsigned MV_PER_LSB_Q16 = 300800,
	parameter int unsigned ALPHA_Q16      = 6554
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bhtc_pkg::op_t                       op,
	input  bhtc_pkg::cfg_t                      cfg,
	input  logic [ADC_BITS-1:0]                 adc_sample,
	input  logic                                armed,
	output bhtc_pkg::dp_status_t                status,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bhtc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tuser
);
	import bhtc_pkg::*;

	localparam int unsigned MUL_A_W = 16;
	localparam int unsigned MUL_B_W = 24;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int unsigned PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic [MUL_B_W-1:0] MV_C        = MUL_B_W'(MV_PER_LSB_Q16);
	localparam logic [MUL_B_W-1:0] ALPHA_C     = MUL_B_W'(ALPHA_Q16);
	localparam logic [MUL_B_W-1:0] ALPHA_INV_C = MUL_B_W'(65536 - ALPHA_Q16);

	// Sample and intermediate registers.
	logic [ADC_BITS-1:0] adc_q;
	logic                armed_q;
	logic [MUL_P_W-1:0]  prod_q;
	logic [31:0]         acc_q;
	logic [VOLT_W-1:0]   volt_q;
	logic [THR_W-1:0]    res_q;
	logic [15:0]         dx_q;
	logic [15:0]         den_q;
	logic [15:0]         dy_abs_q;
	logic                dy_neg_q;
	logic [THR_W-1:0]    y0_q;
	logic [16:0]         rem_q;
	logic [16:0]         divisor_q;
	logic [QUOT_W-1:0]   quot_q;

	// State of the filter and the hover latch.
	logic [FILT_W-1:0]   filter_q;
	logic                prev_armed_q;
	logic [THR_W-1:0]    latched_q;

	// Output register.
	logic                out_valid_q;
	logic [VOLT_W-1:0]   out_volt_q;
	logic [FILT_W-1:0]   out_filt_q;
	logic [THR_W-1:0]    out_hover_q;
	logic                out_locked_q;

	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op)
			OP_VOLT: begin
				mul_a = MUL_A_W'(adc_q);
				mul_b = MV_C;
			end
			OP_FILT_A: begin
				mul_a = MUL_A_W'(filter_q);
				mul_b = ALPHA_INV_C;
			end
			OP_FILT_B: begin
				mul_a = volt_q;
				mul_b = ALPHA_C;
			end
			OP_PROD: begin
				mul_a = dx_q;
				mul_b = MUL_B_W'(dy_abs_q);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Rounded millivolts from the scaling product, saturated to 16 bits.
	logic [MUL_P_W:0]    volt_rnd;
	logic [VOLT_W-1:0]   volt_sat;

	assign volt_rnd = {1'b0, prod_q} + (MUL_P_W + 1)'(32768);
	assign volt_sat = (|volt_rnd[MUL_P_W:32]) ? {VOLT_W{1'b1}} : volt_rnd[31:16];

	// Filter update: blend, or seed with the first sample, then clamp.
	logic [33:0]         mix_sum;
	logic [17:0]         filt_pre;
	logic [FILT_W-1:0]   filt_new;

	always_comb begin
		mix_sum = {2'b0, acc_q} + prod_q[33:0] + 34'd32768;
		if (filter_q == '0) begin
			filt_pre = {2'b0, volt_q};
		end else begin
			filt_pre = mix_sum[33:16];
		end
		if (filt_pre < {4'b0, FILT_MIN_MV}) begin
			filt_new = FILT_MIN_MV;
		end else if (filt_pre > {4'b0, FILT_MAX_MV}) begin
			filt_new = FILT_MAX_MV;
		end else begin
			filt_new = filt_pre[FILT_W-1:0];
		end
	end

	// Segment select on the freshly filtered voltage. An interpolated segment
	// always has x0 <= x < x1, so its span is never zero.
	logic [15:0]         seg_x;
	logic                do_map;
	logic                seg_interp;
	logic [THR_W-1:0]    seg_direct;
	logic [15:0]         seg_x0, seg_x1;
	logic [THR_W-1:0]    seg_y0, seg_y1;
	logic [16:0]         seg_dy;

	assign seg_x  = {2'b0, filter_q};
	assign do_map = !armed_q || !prev_armed_q;

	always_comb begin
		seg_interp = 1'b0;
		seg_direct = cfg.thr_low;
		seg_x0     = cfg.brk_low;
		seg_x1     = cfg.brk_mid_low;
		seg_y0     = cfg.thr_low;
		seg_y1     = cfg.thr_mid_low;
		priority if (!do_map) begin
			seg_direct = latched_q;
		end else if (seg_x >= cfg.brk_high) begin
			seg_direct = cfg.thr_high;
		end else if (seg_x >= cfg.brk_mid_high) begin
			seg_interp = 1'b1;
			seg_x0     = cfg.brk_mid_high;
			seg_x1     = cfg.brk_high;
			seg_y0     = cfg.thr_mid_high;
			seg_y1     = cfg.thr_high;
		end else if (seg_x >= cfg.brk_mid_low) begin
			seg_interp = 1'b1;
			seg_x0     = cfg.brk_mid_low;
			seg_x1     = cfg.brk_mid_high;
			seg_y0     = cfg.thr_mid_low;
			seg_y1     = cfg.thr_mid_high;
		end else if (seg_x >= cfg.brk_low) begin
			seg_interp = 1'b1;
		end else begin
			seg_direct = cfg.thr_low;
		end
		seg_dy = {1'b0, seg_y1} - {1'b0, seg_y0};
	end

	// Divider setup: (2*|num| + den) / (2*den) rounds halves away from zero.
	logic [31:0]         div_dividend;
	logic [17:0]         div_trial;
	logic                div_fit;

	assign div_dividend = {prod_q[30:0], 1'b0} + {16'b0, den_q};
	assign div_trial    = {rem_q, quot_q[QUOT_W-1]};
	assign div_fit      = div_trial >= {1'b0, divisor_q};

	// Final interpolated value, saturated to the throttle range.
	logic signed [17:0]  fin_sum;
	logic [THR_W-1:0]    fin_val;

	always_comb begin
		if (dy_neg_q) begin
			fin_sum = $signed({2'b0, y0_q}) - $signed({2'b0, quot_q});
		end else begin
			fin_sum = $signed({2'b0, y0_q}) + $signed({2'b0, quot_q});
		end
		if (fin_sum < 0) begin
			fin_val = '0;
		end else if (fin_sum > 18'sd65535) begin
			fin_val = {THR_W{1'b1}};
		end else begin
			fin_val = fin_sum[THR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				adc_q   <= adc_sample;
				armed_q <= armed;
			end
			OP_VOLT: begin
				prod_q <= mul_p;
			end
			OP_FILT_A: begin
				volt_q <= volt_sat;
				prod_q <= mul_p;
			end
			OP_FILT_B: begin
				acc_q  <= prod_q[31:0];
				prod_q <= mul_p;
			end
			OP_SEG: begin
				res_q    <= seg_direct;
				dx_q     <= seg_x - seg_x0;
				den_q    <= seg_x1 - seg_x0;
				dy_neg_q <= seg_dy[16];
				dy_abs_q <= seg_dy[16] ? 16'(-seg_dy) : seg_dy[15:0];
				y0_q     <= seg_y0;
			end
			OP_PROD: begin
				prod_q <= mul_p;
			end
			OP_DIV_INIT: begin
				rem_q     <= {1'b0, div_dividend[31:16]};
				quot_q    <= div_dividend[15:0];
				divisor_q <= {den_q, 1'b0};
			end
			OP_DIV_STEP: begin
				if (div_fit) begin
					rem_q  <= 17'(div_trial - {1'b0, divisor_q});
					quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= div_trial[16:0];
					quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
				end
			end
			OP_FINISH: begin
				res_q <= fin_val;
			end
			OP_EMIT: begin
				out_volt_q   <= volt_q;
				out_filt_q   <= filter_q;
				out_hover_q  <= res_q;
				out_locked_q <= armed_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q     <= '0;
			prev_armed_q <= 1'b0;
			latched_q    <= RST_THR_AT_MID_HIGH;
			out_valid_q  <= 1'b0;
		end else begin
			if (op == OP_FILT_C) begin
				filter_q <= filt_new;
			end
			if (op == OP_EMIT) begin
				prev_armed_q <= armed_q;
				if (do_map) begin
					latched_q <= res_q;
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.interp   = seg_interp;
	assign status.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_hover_q, out_filt_q, out_volt_q};
	assign m_tuser  = out_locked_q;

endmodule

// File: hdl/battery_hover_throttle_comp.sv
// ----------------------------------------------------------------------------
// battery_hover_throttle_comp
// Battery voltage filter and hover throttle base compensation.
//
// The slave stream carries one averaged battery ADC code per transfer in
// s_tdata and the armed flag in s_tuser. Each accepted sample produces one
// transfer on the master stream: raw millivolts, filtered millivolts, the hover
// throttle base and the lock flag (equal to armed).
// The block works on one sample at a time. When the hover base comes straight
// from a register or from the latch, the result goes from the segment select
// to the output register; when it is interpolated, the 16-step restoring
// divider runs in between. A new sample is taken in the cycle after the result
// is loaded into the output register.
// The output register holds a result until m_tready; while it is full the
// next sample is still computed and waits only at the final load.
// Reset loads the configuration registers with their defaults, clears the
// filter (the next sample seeds it) and the armed history, and sets the
// latched hover base to the default mid-high throttle.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module battery_hover_throttle_comp #(
	parameter int unsigned ADC_BITS       = 12,
	parameter int unsigned MV_PER_LSB_Q16 = 300800,
	parameter int unsigned ALPHA_Q16      = 6554
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0]  s_tdata,   // adc_sample
	input  logic                                   s_tuser,   // armed
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [bhtc_pkg::OUT_TDATA_W-1:0]       m_tdata,   // voltage_mv, filtered_mv,
	                                                          // hover_base
	output logic                                   m_tuser,   // throttle_locked
	input  logic                                   cfg_we,
	input  logic [bhtc_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [bhtc_pkg::REG_W-1:0]             cfg_data
);
	import bhtc_pkg::*;

	cfg_t       cfg;
	op_t        op;
	dp_status_t status;

	bhtc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bhtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.op       (op)
	);

	bhtc_datapath #(
		.ADC_BITS       (ADC_BITS),
		.MV_PER_LSB_Q16 (MV_PER_LSB_Q16),
		.ALPHA_Q16      (ALPHA_Q16)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.cfg        (cfg),
		.adc_sample (s_tdata[ADC_BITS-1:0]),
		.armed      (s_tuser),
		.status     (status),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for battery_hover_throttle_comp. Samples go in on the
// slave stream and a scoreboard class predicts, for every accepted transfer,
// the raw and filtered millivolts, the hover base and the lock flag. Each
// master transfer is compared field by field against the oldest prediction.
// A short directed run at the reset settings is followed by random phases.
// Each phase has its own breakpoint and throttle setting and one of four mixes
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import bhtc_pkg::*;

	localparam int unsigned ADC_BITS       = 12;
	localparam int unsigned MV_PER_LSB_Q16 = 300800;
	localparam int unsigned ALPHA_Q16      = 6554;
	localparam int unsigned IN_TDATA_W     = ((ADC_BITS + 7) / 8) * 8;
	localparam int unsigned FILT_LSB       = VOLT_W;
	localparam int unsigned HOVER_LSB      = VOLT_W + FILT_W;
	localparam int NUM_REGS      = 8;
	localparam int NUM_SETTINGS  = 8;
	localparam int PHASE_ITEMS   = 85;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int MAX_PRINTS    = 40;
	localparam int NUM_DIRECTED  = 20;

	// Directed samples: seeding from zero while armed, a climb into the upper
	// clamp, edges of armed, and alternating bit patterns of the ADC code.
	localparam logic [11:0] DIR_ADC [NUM_DIRECTED] = '{
		12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
		12'd4095, 12'd4095, 12'd4095, 12'hAAA, 12'h555, 12'h555, 12'd2048,
		12'd1, 12'd4094, 12'd2731, 12'd2457, 12'd1960, 12'd2900
	};
	localparam logic DIR_ARM [NUM_DIRECTED] = '{
		1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
		1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0
	};

	typedef struct {
		logic [VOLT_W-1:0] volt_mv;
		logic [FILT_W-1:0] filt_mv;
		logic [THR_W-1:0]  hover;
		logic              locked;
	} hover_result_t;

	class hover_scoreboard;
		logic [REG_W-1:0]  regs [NUM_REGS];
		logic [FILT_W-1:0] filt_q;
		logic              armed_q;
		logic [THR_W-1:0]  hold_q;
		hover_result_t     expected_q [$];
		int                errors;
		int                checked;

		function new();
			regs[REG_VOLT_BREAK_LOW]      = RST_VOLT_BREAK_LOW;
			regs[REG_VOLT_BREAK_MID_LOW]  = RST_VOLT_BREAK_MID_LOW;
			regs[REG_VOLT_BREAK_MID_HIGH] = RST_VOLT_BREAK_MID_HIGH;
			regs[REG_VOLT_BREAK_HIGH]     = RST_VOLT_BREAK_HIGH;
			regs[REG_THR_AT_LOW]          = RST_THR_AT_LOW;
			regs[REG_THR_AT_MID_LOW]      = RST_THR_AT_MID_LOW;
			regs[REG_THR_AT_MID_HIGH]     = RST_THR_AT_MID_HIGH;
			regs[REG_THR_AT_HIGH]         = RST_THR_AT_HIGH;
			filt_q  = '0;
			armed_q = 1'b0;
			hold_q  = RST_THR_AT_MID_HIGH;
			errors  = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
			regs[idx] = val;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Linear interpolation, rounded to nearest with halves away from zero.
		function longint seg_interp(longint x0, longint y0, longint x1, longint y1,
				longint x);
			longint span, num, an, ad, q, r;
			bit neg;
			span = x1 - x0;
			if (span == 0)
				return y0;
			num = (x - x0) * (y1 - y0);
			neg = (num < 0) != (span < 0);
			an  = (num < 0) ? -num : num;
			ad  = (span < 0) ? -span : span;
			q   = (an * 2 + ad) / (ad * 2);
			r   = neg ? y0 - q : y0 + q;
			if (r < 0)
				r = 0;
			if (r > 65535)
				r = 65535;
			return r;
		endfunction

		function longint map_hover(longint x);
			longint bl, bml, bmh, bh, tl, tml, tmh, th;
			bl  = longint'(regs[REG_VOLT_BREAK_LOW]);
			bml = longint'(regs[REG_VOLT_BREAK_MID_LOW]);
			bmh = longint'(regs[REG_VOLT_BREAK_MID_HIGH]);
			bh  = longint'(regs[REG_VOLT_BREAK_HIGH]);
			tl  = longint'(regs[REG_THR_AT_LOW]);
			tml = longint'(regs[REG_THR_AT_MID_LOW]);
			tmh = longint'(regs[REG_THR_AT_MID_HIGH]);
			th  = longint'(regs[REG_THR_AT_HIGH]);
			if (x >= bh)
				return th;
			if (x >= bmh)
				return seg_interp(bmh, tmh, bh, th, x);
			if (x >= bml)
				return seg_interp(bml, tml, bmh, tmh, x);
			if (x >= bl)
				return seg_interp(bl, tl, bml, tml, x);
			return tl;
		endfunction

		function void note_sample(logic [ADC_BITS-1:0] adc, logic armed);
			longint v, f, hv;
			hover_result_t res;
			v = (longint'(adc) * longint'(MV_PER_LSB_Q16) + 32768) >> 16;
			if (v > 65535)
				v = 65535;
			// A zero filter value means the filter has not been seeded yet.
			if (filt_q == '0)
				f = v;
			else
				f = (longint'(filt_q) * (65536 - longint'(ALPHA_Q16))
					+ v * longint'(ALPHA_Q16) + 32768) >> 16;
			if (f < longint'(FILT_MIN_MV))
				f = longint'(FILT_MIN_MV);
			if (f > longint'(FILT_MAX_MV))
				f = longint'(FILT_MAX_MV);
			filt_q = f[FILT_W-1:0];
			if (!armed || !armed_q) begin
				hv = map_hover(f);
				hold_q = hv[THR_W-1:0];
			end else begin
				hv = longint'(hold_q);
			end
			armed_q = armed;
			res.volt_mv = v[VOLT_W-1:0];
			res.filt_mv = f[FILT_W-1:0];
			res.hover   = hv[THR_W-1:0];
			res.locked  = armed;
			expected_q.push_back(res);
		endfunction

		task report_mismatch(string msg);
			if (errors < MAX_PRINTS)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] data, logic user);
			hover_result_t want;
			logic [VOLT_W-1:0] got_volt;
			logic [FILT_W-1:0] got_filt;
			logic [THR_W-1:0]  got_hover;
			got_volt  = data[VOLT_W-1:0];
			got_filt  = data[FILT_LSB +: FILT_W];
			got_hover = data[HOVER_LSB +: THR_W];
			if (expected_q.size() == 0) begin
				report_mismatch("result transfer with no sample outstanding");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got_volt !== want.volt_mv)
				report_mismatch($sformatf("voltage_mv got %0d want %0d",
					got_volt, want.volt_mv));
			if (got_filt !== want.filt_mv)
				report_mismatch($sformatf("filtered_mv got %0d want %0d",
					got_filt, want.filt_mv));
			if (got_hover !== want.hover)
				report_mismatch($sformatf("hover_base got %0d want %0d",
					got_hover, want.hover));
			if (user !== want.locked)
				report_mismatch($sformatf("throttle_locked got %0b want %0b",
					user, want.locked));
		endtask
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // adc_sample
	logic                   s_tuser   = 1'b0; // armed
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // voltage_mv, filtered_mv, hover_base
	logic                   m_tuser;          // throttle_locked
	logic                   cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_index = '0;
	logic [REG_W-1:0]       cfg_data  = '0;

	hover_scoreboard sb = new();
	int cycle_count = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int samples_sent = 0;
	int adc_target  = 2300;
	logic arm_level = 1'b0;

	battery_hover_throttle_comp #(
		.ADC_BITS      (ADC_BITS),
		.MV_PER_LSB_Q16(MV_PER_LSB_Q16),
		.ALPHA_Q16     (ALPHA_Q16)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: check every transfer, then pick the ready level for the next
	// cycle.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_sample(logic [ADC_BITS-1:0] adc, logic armed);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(adc);
		s_tuser  <= armed;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sample(adc, armed);
		samples_sent++;
	endtask

	// Every sample yields a result, so the block is idle once none is owed.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_setting(int sel);
		logic [REG_W-1:0] v [NUM_REGS];
		int i;
		case (sel)
			0: begin
				v[REG_VOLT_BREAK_LOW]      = RST_VOLT_BREAK_LOW;
				v[REG_VOLT_BREAK_MID_LOW]  = RST_VOLT_BREAK_MID_LOW;
				v[REG_VOLT_BREAK_MID_HIGH] = RST_VOLT_BREAK_MID_HIGH;
				v[REG_VOLT_BREAK_HIGH]     = RST_VOLT_BREAK_HIGH;
				v[REG_THR_AT_LOW]          = RST_THR_AT_LOW;
				v[REG_THR_AT_MID_LOW]      = RST_THR_AT_MID_LOW;
				v[REG_THR_AT_MID_HIGH]     = RST_THR_AT_MID_HIGH;
				v[REG_THR_AT_HIGH]         = RST_THR_AT_HIGH;
			end
			1: begin
				// Ordered breakpoints inside the clamp window, random throttles.
				v[REG_VOLT_BREAK_LOW]      = REG_W'($urandom_range(9000, 9900));
				v[REG_VOLT_BREAK_MID_LOW]  = v[REG_VOLT_BREAK_LOW]
					+ REG_W'($urandom_range(1000));
				v[REG_VOLT_BREAK_MID_HIGH] = v[REG_VOLT_BREAK_MID_LOW]
					+ REG_W'($urandom_range(1000));
				v[REG_VOLT_BREAK_HIGH]     = v[REG_VOLT_BREAK_MID_HIGH]
					+ REG_W'($urandom_range(1000));
				v[REG_THR_AT_LOW]          = REG_W'($urandom());
				v[REG_THR_AT_MID_LOW]      = REG_W'($urandom());
				v[REG_THR_AT_MID_HIGH]     = REG_W'($urandom());
				v[REG_THR_AT_HIGH]         = REG_W'($urandom());
			end
			2: begin
				v[REG_VOLT_BREAK_LOW]      = '0;
				v[REG_VOLT_BREAK_MID_LOW]  = '0;
				v[REG_VOLT_BREAK_MID_HIGH] = '0;
				v[REG_VOLT_BREAK_HIGH]     = '0;
				v[REG_THR_AT_LOW]          = '1;
				v[REG_THR_AT_MID_LOW]      = '0;
				v[REG_THR_AT_MID_HIGH]     = '1;
				v[REG_THR_AT_HIGH]         = '0;
			end
			3: begin
				v[REG_VOLT_BREAK_LOW]      = '1;
				v[REG_VOLT_BREAK_MID_LOW]  = '1;
				v[REG_VOLT_BREAK_MID_HIGH] = '1;
				v[REG_VOLT_BREAK_HIGH]     = '1;
				v[REG_THR_AT_LOW]          = '0;
				v[REG_THR_AT_MID_LOW]      = '1;
				v[REG_THR_AT_MID_HIGH]     = '0;
				v[REG_THR_AT_HIGH]         = '1;
			end
			4: begin
				// Two pairs of equal breakpoints.
				v[REG_VOLT_BREAK_LOW]      = 16'd10000;
				v[REG_VOLT_BREAK_MID_LOW]  = 16'd10000;
				v[REG_VOLT_BREAK_MID_HIGH] = 16'd12000;
				v[REG_VOLT_BREAK_HIGH]     = 16'd12000;
				v[REG_THR_AT_LOW]          = REG_W'($urandom());
				v[REG_THR_AT_MID_LOW]      = REG_W'($urandom());
				v[REG_THR_AT_MID_HIGH]     = REG_W'($urandom());
				v[REG_THR_AT_HIGH]         = REG_W'($urandom());
			end
			5: begin
				// Breakpoints out of order; the comparisons still run top down.
				v[REG_VOLT_BREAK_LOW]      = 16'd12500;
				v[REG_VOLT_BREAK_MID_LOW]  = 16'd12900;
				v[REG_VOLT_BREAK_MID_HIGH] = 16'd9400;
				v[REG_VOLT_BREAK_HIGH]     = 16'd11800;
				v[REG_THR_AT_LOW]          = '0;
				v[REG_THR_AT_MID_LOW]      = '1;
				v[REG_THR_AT_MID_HIGH]     = '1;
				v[REG_THR_AT_HIGH]         = '0;
			end
			6: begin
				for (i = 0; i < NUM_REGS; i++)
					v[i] = REG_W'($urandom());
			end
			default: begin
				// Steep full-scale swings over the whole window.
				v[REG_VOLT_BREAK_LOW]      = 16'd9000;
				v[REG_VOLT_BREAK_MID_LOW]  = 16'd9001;
				v[REG_VOLT_BREAK_MID_HIGH] = 16'd12999;
				v[REG_VOLT_BREAK_HIGH]     = 16'd13000;
				v[REG_THR_AT_LOW]          = '0;
				v[REG_THR_AT_MID_LOW]      = '1;
				v[REG_THR_AT_MID_HIGH]     = '0;
				v[REG_THR_AT_HIGH]         = '1;
			end
		endcase
		for (i = 0; i < NUM_REGS; i++)
			write_reg(REG_IDX_W'(i), v[i]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// The sample drifts around a target that moves now and then, so the slow
	// filter sweeps through every segment of the table; a few samples are noise.
	task automatic next_random_item(output logic [ADC_BITS-1:0] adc,
			output logic armed);
		int pick, val, noise;
		if ($urandom_range(15) == 0) begin
			pick = $urandom_range(9);
			if (pick < 8)
				adc_target = $urandom_range(1900, 2900);
			else if (pick == 8)
				adc_target = $urandom_range(4095);
			else
				adc_target = $urandom_range(1) ? 4095 : 0;
		end
		if ($urandom_range(19) == 0) begin
			val = $urandom_range(4095);
		end else begin
			noise = int'($urandom_range(80)) - 40;
			val   = adc_target + noise;
		end
		if (val < 0)
			val = 0;
		if (val > 4095)
			val = 4095;
		if ($urandom_range(7) == 0)
			arm_level = !arm_level;
		adc   = val[ADC_BITS-1:0];
		armed = arm_level;
	endtask

	initial begin
		int ph, k;
		logic [ADC_BITS-1:0] adc;
		logic armed;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < NUM_DIRECTED; k++)
			send_sample(DIR_ADC[k], DIR_ARM[k]);

		for (ph = 0; ph < NUM_SETTINGS; ph++) begin
			wait_idle();
			apply_setting(ph);
			case (ph % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 55;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 55;
				end
				default: begin
					idle_pct  = 31;
					stall_pct = 31;
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				next_random_item(adc, armed);
				send_sample(adc, armed);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

		$display("summary: %0d samples sent, %0d results checked, %0d mismatches",
			samples_sent, sb.checked, sb.errors);
		$display("summary: %0d register settings, gaps and stalls on both streams",
			NUM_SETTINGS);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
